// ===== rtl/core/pn2d_pkg.sv =====
// shared constants and types for the 2d gradient noise pipeline
// no dependencies; imported by pn2d_qsine and perlin_noise_2d
`default_nettype none

package pn2d_pkg;

  // corner hash multipliers
  localparam logic [31:0] HASH_K1 = 32'd3284157443;
  localparam logic [31:0] HASH_K2 = 32'd1911520717;
  localparam logic [31:0] HASH_K3 = 32'd2048419325;

  // quarter-wave sine polynomial coefficients, q16
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [15:0] SIN_B = 16'd42334;
  localparam logic [12:0] SIN_C = 13'd4926;

  // one in q16, and the largest sine value in q1.14
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [14:0] SIN_MAX  = 15'd16384;

  // register stages from input to output register
  localparam int unsigned NSTG = 15;

  // stages inside the sine unit
  localparam int unsigned SIN_LAT = 4;

  typedef logic signed [17:0] off_t;   // q16 offset, upper corner included
  typedef logic signed [15:0] grad_t;  // gradient component, q1.14
  typedef logic signed [19:0] dot_t;   // corner dot product, q16
  typedef logic signed [19:0] wgt_t;   // smoothstep weight, q16
  typedef logic signed [27:0] row_t;   // blend along x, q16
  typedef logic signed [35:0] val_t;   // final blend, q16

endpackage

`default_nettype wire

// ===== rtl/core/pn2d_qsine.sv =====
// four-stage quarter-wave sine unit, sin(pi/2 z) in q1.14 from z in q16
// depends on pn2d_pkg
`default_nettype none

module pn2d_qsine
  import pn2d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [16:0] z_i,
  output logic      [14:0] s_o
);

  logic [16:0] z2_r;
  logic [16:0] za_r;
  logic [16:0] zb_r;
  logic [16:0] zc_r;
  logic [16:0] z2b_r;
  logic [15:0] tb_r;
  logic [16:0] ta_r;
  logic [14:0] s_r;

  logic [33:0] z2_full;
  logic [29:0] ct_full;
  logic [12:0] ct;
  logic [32:0] bt_full;
  logic [15:0] bt;
  logic [33:0] at_full;
  logic [16:0] at;
  logic [14:0] at_q14;

  // stage 1: z squared
  assign z2_full = z_i * z_i;
  // stage 2: c*z2 taken from b
  assign ct_full = SIN_C * z2_r;
  assign ct      = ct_full[28:16];
  // stage 3: that times z2 taken from a
  assign bt_full = tb_r * z2b_r;
  assign bt      = bt_full[31:16];
  // stage 4: times z, to q1.14, clamp
  assign at_full = ta_r * zc_r;
  assign at      = at_full[32:16];
  assign at_q14  = at[16:2];

  always_ff @(posedge clk) begin
    if (en) begin
      z2_r  <= z2_full[32:16];
      za_r  <= z_i;
      tb_r  <= SIN_B - {3'd0, ct};
      z2b_r <= z2_r;
      zb_r  <= za_r;
      ta_r  <= SIN_A - {1'b0, bt};
      zc_r  <= zb_r;
      s_r   <= (at_q14 > SIN_MAX) ? SIN_MAX : at_q14;
    end
  end

  assign s_o = s_r;

endmodule

`default_nettype wire

// ===== rtl/core/perlin_noise_2d.sv =====
// 2d gradient noise, one sample per request, fifteen register stages
// depends on pn2d_pkg and pn2d_qsine
// throughput: one request per cycle while the output is not stalled; a stalled output freezes the whole pipe
// reset: synchronous active-low rst_n clears all stage valid bits only
`default_nettype none

module perlin_noise_2d
  import pn2d_pkg::*;
#(
  parameter int PHASE_BITS = 10,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // x_coord [31:0], y_coord [63:32]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // noise_value [15:0]
);

  localparam int SHR = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
  localparam int SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int OW  = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 2;
  localparam int RW  = PHASE_BITS - 2;
  localparam int ZSH = 18 - PHASE_BITS;

  logic            pipe_en;
  logic [NSTG:1]   vld_r;

  // ---------------- stage 1: split coordinates ----------------
  logic [31:0]     cx0_r, cy0_r;
  off_t            dx_p [1:9];
  off_t            dy_p [1:9];

  function automatic logic [31:0] split_corner(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] ip;
    mag = v[31] ? (32'd0 - v) : v;
    ip  = mag >> FRAC_BITS;
    return v[31] ? (32'd0 - ip) : ip;
  endfunction

  function automatic off_t split_off(input logic [31:0] v);
    logic [31:0]          mag;
    logic [31:0]          fr;
    logic signed [OW-1:0] off;
    logic signed [OW-1:0] sh;
    mag = v[31] ? (32'd0 - v) : v;
    fr  = mag & ((32'd1 << FRAC_BITS) - 32'd1);
    off = v[31] ? -$signed(OW'(fr)) : $signed(OW'(fr));
    sh  = (off <<< SHL) >>> SHR;
    return off_t'(sh);
  endfunction

  // ---------------- stage 2: first hash product, t squared ----------------
  logic [31:0]     ax2_r [2];
  logic [31:0]     cy2_r [2];
  logic [16:0]     tx2_r, ty2_r;
  logic [35:0]     tx_sq, ty_sq;

  // ---------------- stage 3: second hash product, weights ----------------
  logic [31:0]     ax3_r [2];
  logic [31:0]     bm_r  [4];
  wgt_t            wx_p [3:11];
  wgt_t            wy_p [3:13];

  // ---------------- stage 4: final hash ----------------
  logic [31:0]     h_r [4];

  // ---------------- stage 5: phase split ----------------
  logic [16:0]     z_r  [4];
  logic [16:0]     zc_r [4];
  logic [7:0]      quad_p [5:9];

  // ---------------- sine outputs, stage 9 ----------------
  logic [14:0]     sz [4];
  logic [14:0]     sc [4];
  grad_t           sn [4];
  grad_t           cs [4];

  // ---------------- stages 10..15 ----------------
  logic signed [33:0] px_r [4];
  logic signed [33:0] py_r [4];
  dot_t               n_r  [4];
  logic signed [40:0] pb_r [2];
  dot_t               nb_r [2];
  row_t               ix_r [2];
  logic signed [48:0] pv_r;
  row_t               ixv_r;
  logic [15:0]        q_r;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic wgt_t smooth_w(input off_t t, input logic [16:0] t2);
    logic signed [20:0] u;
    logic signed [38:0] p;
    u = 21'sd196608 - (21'(t) <<< 1);
    p = u * $signed({1'b0, t2});
    return wgt_t'(p >>> 16);
  endfunction

  function automatic logic [15:0] sat16(input val_t v);
    val_t q;
    q = v >>> 4;
    if (q > 36'sd32767) return 16'h7fff;
    else if (q < -36'sd32768) return 16'h8000;
    else return q[15:0];
  endfunction

  assign pipe_en   = !vld_r[NSTG] || out_tready;
  assign in_tready = pipe_en;
  assign tx_sq     = dx_p[1] * dx_p[1];
  assign ty_sq     = dy_p[1] * dy_p[1];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[NSTG-1:1], in_tvalid};
    end
  end

  // front end: split, hash, weights, phase
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cx0_r    <= split_corner(in_tdata[31:0]);
      cy0_r    <= split_corner(in_tdata[63:32]);
      dx_p[1]  <= split_off(in_tdata[31:0]);
      dy_p[1]  <= split_off(in_tdata[63:32]);
      for (int k = 2; k <= 9; k++) begin
        dx_p[k] <= dx_p[k-1];
        dy_p[k] <= dy_p[k-1];
      end

      ax2_r[0] <= cx0_r * HASH_K1;
      ax2_r[1] <= (cx0_r + 32'd1) * HASH_K1;
      cy2_r[0] <= cy0_r;
      cy2_r[1] <= cy0_r + 32'd1;
      tx2_r    <= tx_sq[32:16];
      ty2_r    <= ty_sq[32:16];

      ax3_r    <= ax2_r;
      for (int c = 0; c < 4; c++) begin
        bm_r[c] <= (cy2_r[c/2] ^ rot16(ax2_r[c%2])) * HASH_K2;
      end
      wx_p[3]  <= smooth_w(dx_p[2], tx2_r);
      wy_p[3]  <= smooth_w(dy_p[2], ty2_r);
      for (int k = 4; k <= 11; k++) wx_p[k] <= wx_p[k-1];
      for (int k = 4; k <= 13; k++) wy_p[k] <= wy_p[k-1];

      for (int c = 0; c < 4; c++) begin
        h_r[c] <= (ax3_r[c%2] ^ rot16(bm_r[c])) * HASH_K3;
      end

      for (int c = 0; c < 4; c++) begin
        z_r[c]  <= {1'b0, h_r[c][32-PHASE_BITS +: RW], ZSH'(0)};
        zc_r[c] <= ONE_Q16 - {1'b0, h_r[c][32-PHASE_BITS +: RW], ZSH'(0)};
        quad_p[5][2*c +: 2] <= h_r[c][31 -: 2];
      end
      for (int k = 6; k <= 9; k++) quad_p[k] <= quad_p[k-1];
    end
  end

  // sine and cosine for each corner
  for (genvar c = 0; c < 4; c++) begin : g_sin
    pn2d_qsine u_sz (.clk(clk), .en(pipe_en), .z_i(z_r[c]),  .s_o(sz[c]));
    pn2d_qsine u_sc (.clk(clk), .en(pipe_en), .z_i(zc_r[c]), .s_o(sc[c]));
  end

  // rotate gradient into its quadrant
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      unique case (quad_p[9][2*c +: 2])
        2'd0: begin sn[c] = grad_t'(sz[c]);  cs[c] = grad_t'(sc[c]);  end
        2'd1: begin sn[c] = grad_t'(sc[c]);  cs[c] = -grad_t'(sz[c]); end
        2'd2: begin sn[c] = -grad_t'(sz[c]); cs[c] = -grad_t'(sc[c]); end
        default: begin sn[c] = -grad_t'(sc[c]); cs[c] = grad_t'(sz[c]); end
      endcase
    end
  end

  // back end: dots, blends, saturation
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int c = 0; c < 4; c++) begin
        px_r[c] <= ((c % 2) == 1 ? off_t'(dx_p[9] - 18'sd65536) : dx_p[9]) * sn[c];
        py_r[c] <= ((c / 2) == 1 ? off_t'(dy_p[9] - 18'sd65536) : dy_p[9]) * cs[c];
      end

      for (int c = 0; c < 4; c++) begin
        n_r[c] <= dot_t'((35'(px_r[c]) + 35'(py_r[c])) >>> 14);
      end

      for (int r = 0; r < 2; r++) begin
        pb_r[r] <= (21'(n_r[2*r+1]) - 21'(n_r[2*r])) * wx_p[11];
        nb_r[r] <= n_r[2*r];
      end

      for (int r = 0; r < 2; r++) begin
        ix_r[r] <= row_t'(nb_r[r]) + row_t'(pb_r[r] >>> 16);
      end

      pv_r  <= (29'(ix_r[1]) - 29'(ix_r[0])) * wy_p[13];
      ixv_r <= ix_r[0];

      q_r   <= sat16(val_t'(ixv_r) + val_t'(pv_r >>> 16));
    end
  end

  assign out_tvalid = vld_r[NSTG];
  assign out_tdata  = q_r;

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a stall freezes every stage valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  // an accepted request lands in the first stage
  a_accept_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[1])
    else $error("accepted request lost at entry");

endmodule

`default_nettype wire
